[hw/rtl/bstp_pkg.sv]
// ----------------------------------------------------------------------------
// bstp_pkg
// Shared types and constants of the bencode scalar token parser.
// ----------------------------------------------------------------------------
package bstp_pkg;

    // integer token width; accepted range is the signed range of this width
    localparam int VALUE_WIDTH = 64;
    localparam int OUT_W       = 64;
    localparam int LEN_W       = 31;
    localparam int BYTE_W      = 8;
    localparam int KIND_W      = 2;
    localparam int CODE_W      = 3;
    // accumulator holds either an integer magnitude or a string length
    localparam int ACC_W       = (VALUE_WIDTH > LEN_W) ? VALUE_WIDTH : LEN_W;
    localparam int ACC10_W     = ACC_W + 4;

    localparam logic [ACC10_W-1:0] POS_LIMIT =
        (ACC10_W'(1) << (VALUE_WIDTH - 1)) - ACC10_W'(1);
    localparam logic [ACC10_W-1:0] NEG_LIMIT = ACC10_W'(1) << (VALUE_WIDTH - 1);

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = {LEN_W{1'b1}};

    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_E     = 8'h65;
    localparam logic [BYTE_W-1:0] CH_I     = 8'h69;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;

    localparam logic [KIND_W-1:0] KIND_INT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd3;

    localparam logic [CODE_W-1:0] ERR_START    = 3'd0;
    localparam logic [CODE_W-1:0] ERR_DIGIT    = 3'd1;
    localparam logic [CODE_W-1:0] ERR_EMPTY    = 3'd2;
    localparam logic [CODE_W-1:0] ERR_OVERFLOW = 3'd3;
    localparam logic [CODE_W-1:0] ERR_LENGTH   = 3'd4;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_INT     = 2'd1,
        MODE_LEN     = 2'd2,
        MODE_PAYLOAD = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic               negative;
        logic               digit_seen;
        logic [ACC_W-1:0]   acc;
        logic [LEN_W-1:0]   remaining;
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]       result_kind;
        logic signed [OUT_W-1:0] integer_value;
        logic [BYTE_W-1:0]       payload_byte;
        logic                    last_of_string;
        logic [CODE_W-1:0]       error_code;
    } t_result;

    localparam t_state IDLE_STATE = '{
        mode:       MODE_IDLE,
        negative:   1'b0,
        digit_seen: 1'b0,
        acc:        '0,
        remaining:  '0
    };

endpackage

[hw/rtl/bstp_if.sv]
// ----------------------------------------------------------------------------
// bstp_in_if / bstp_out_if
// Valid/ready channels for stream bytes in and parse results out.
// ----------------------------------------------------------------------------
interface bstp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface bstp_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         result_kind;
    logic signed [63:0] integer_value;
    logic [7:0]         payload_byte;
    logic               last_of_string;
    logic [2:0]         error_code;

    modport source (output valid, output result_kind, output integer_value,
                    output payload_byte, output last_of_string, output error_code,
                    input ready);
    modport sink   (input valid, input result_kind, input integer_value,
                    input payload_byte, input last_of_string, input error_code,
                    output ready);
endinterface

[hw/rtl/bstp_step.sv]
// ----------------------------------------------------------------------------
// bstp_step
// Next-state and result logic for one stream byte.
// ----------------------------------------------------------------------------
module bstp_step (
    input  bstp_pkg::t_state          i_state,
    input  logic [7:0]                i_byte,
    input  logic [bstp_pkg::LEN_W-1:0] i_max_len,
    output bstp_pkg::t_state          o_state,
    output logic                      o_emit,
    output bstp_pkg::t_result         o_result
);
    import bstp_pkg::*;

    logic                   is_digit;
    logic [3:0]             digit;
    logic [ACC10_W-1:0]     acc10;
    logic [ACC10_W-1:0]     max_ext;
    logic [ACC10_W-1:0]     int_limit;
    logic [VALUE_WIDTH-1:0] mag;
    logic [VALUE_WIDTH-1:0] value;

    assign is_digit  = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign digit     = is_digit ? 4'(i_byte - CH_ZERO) : 4'd0;
    // acc * 10 + digit
    assign acc10     = ACC10_W'({i_state.acc, 3'b000}) + ACC10_W'({i_state.acc, 1'b0})
                     + ACC10_W'(digit);
    assign max_ext   = ACC10_W'(i_max_len);
    assign int_limit = i_state.negative ? NEG_LIMIT : POS_LIMIT;
    assign mag       = i_state.acc[VALUE_WIDTH-1:0];
    assign value     = i_state.negative ? (VALUE_WIDTH'(0) - mag) : mag;

    always_comb begin
        o_state  = i_state;
        o_emit   = 1'b0;
        o_result = '0;
        case (i_state.mode)
            MODE_IDLE: begin
                if (i_byte == CH_I) begin
                    o_state      = IDLE_STATE;
                    o_state.mode = MODE_INT;
                end else if (is_digit) begin
                    o_state = IDLE_STATE;
                    if (LEN_W'(digit) > i_max_len) begin
                        o_emit               = 1'b1;
                        o_result.result_kind = KIND_ERROR;
                        o_result.error_code  = ERR_LENGTH;
                    end else begin
                        o_state.mode = MODE_LEN;
                        o_state.acc  = ACC_W'(digit);
                    end
                end else begin
                    o_state              = IDLE_STATE;
                    o_emit               = 1'b1;
                    o_result.result_kind = KIND_ERROR;
                    o_result.error_code  = ERR_START;
                end
            end
            MODE_INT: begin
                if (i_byte == CH_MINUS && !i_state.digit_seen && !i_state.negative) begin
                    o_state.negative = 1'b1;
                end else if (i_byte == CH_E) begin
                    o_state = IDLE_STATE;
                    o_emit  = 1'b1;
                    if (!i_state.digit_seen) begin
                        o_result.result_kind = KIND_ERROR;
                        o_result.error_code  = ERR_EMPTY;
                    end else begin
                        o_result.result_kind   = KIND_INT;
                        o_result.integer_value = OUT_W'($signed(value));
                    end
                end else if (!is_digit) begin
                    o_state              = IDLE_STATE;
                    o_emit               = 1'b1;
                    o_result.result_kind = KIND_ERROR;
                    o_result.error_code  = ERR_DIGIT;
                end else if (acc10 > int_limit) begin
                    o_state              = IDLE_STATE;
                    o_emit               = 1'b1;
                    o_result.result_kind = KIND_ERROR;
                    o_result.error_code  = ERR_OVERFLOW;
                end else begin
                    o_state.acc        = acc10[ACC_W-1:0];
                    o_state.digit_seen = 1'b1;
                end
            end
            MODE_LEN: begin
                if (i_byte == CH_COLON) begin
                    if (i_state.acc == '0) begin
                        o_state              = IDLE_STATE;
                        o_emit               = 1'b1;
                        o_result.result_kind = KIND_EMPTY;
                    end else begin
                        o_state.remaining = i_state.acc[LEN_W-1:0];
                        o_state.acc       = '0;
                        o_state.mode      = MODE_PAYLOAD;
                    end
                end else if (!is_digit) begin
                    o_state              = IDLE_STATE;
                    o_emit               = 1'b1;
                    o_result.result_kind = KIND_ERROR;
                    o_result.error_code  = ERR_DIGIT;
                end else if (acc10 > max_ext) begin
                    o_state              = IDLE_STATE;
                    o_emit               = 1'b1;
                    o_result.result_kind = KIND_ERROR;
                    o_result.error_code  = ERR_LENGTH;
                end else begin
                    o_state.acc = acc10[ACC_W-1:0];
                end
            end
            MODE_PAYLOAD: begin
                o_emit                = 1'b1;
                o_result.result_kind  = KIND_BYTE;
                o_result.payload_byte = i_byte;
                if (i_state.remaining <= LEN_W'(1)) begin
                    o_state                 = IDLE_STATE;
                    o_result.last_of_string = 1'b1;
                end else begin
                    o_state.remaining = i_state.remaining - LEN_W'(1);
                end
            end
            default: begin
                o_state = IDLE_STATE;
            end
        endcase
    end

endmodule

[hw/rtl/bencode_scalar_token_parser.sv]
// ----------------------------------------------------------------------------
// bencode_scalar_token_parser
// Parses bencode integer and byte-string tokens from a byte stream.
//
//   channel  dir  handshake    payload
//   i_in     in   valid/ready  stream_byte
//   o_out    out  valid/ready  result_kind, integer_value, payload_byte,
//                              last_of_string, error_code
//   i_cfg_*  in   write enable max_string_length (31 bits)
//
// one byte per cycle sustained while the output is not stalled; a byte is held in the
// input register and its result (if any) is then registered in the output register
// the accumulator update (acc * 10 + digit and its limit compare) sets the path
// synchronous active-low reset returns the parser to idle, limit to 2^31-1
// a stalled output holds the input register; a byte with no result still
// waits for the output register to be free
// ----------------------------------------------------------------------------
module bencode_scalar_token_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bstp_pkg::LEN_W-1:0] i_cfg_wdata,
    bstp_in_if.sink                    i_in,
    bstp_out_if.source                 o_out
);
    import bstp_pkg::*;

    logic             r_in_valid, n_in_valid;
    logic [7:0]       r_in_byte, n_in_byte;
    t_state           r_state, n_state;
    logic [LEN_W-1:0] r_max_len, n_max_len;
    logic             r_out_valid, n_out_valid;
    t_result          r_out, n_out;

    t_state           step_state;
    logic             step_emit;
    t_result          step_result;
    logic             advance;
    logic             accept;

    bstp_step u_step (
        .i_state   (r_state),
        .i_byte    (r_in_byte),
        .i_max_len (r_max_len),
        .o_state   (step_state),
        .o_emit    (step_emit),
        .o_result  (step_result)
    );

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_in_byte   = r_in_byte;
        n_state     = r_state;
        n_max_len   = r_max_len;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (i_cfg_we) begin
            n_max_len = i_cfg_wdata;
        end
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (advance) begin
            n_in_valid = 1'b0;
            n_state    = step_state;
            if (step_emit) begin
                n_out_valid = 1'b1;
                n_out       = step_result;
            end
        end
        if (accept) begin
            n_in_valid = 1'b1;
            n_in_byte  = i_in.stream_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= IDLE_STATE;
            r_max_len   <= MAX_LEN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_state     <= n_state;
            r_max_len   <= n_max_len;
            r_out_valid <= n_out_valid;
        end
        r_in_byte <= n_in_byte;
        r_out     <= n_out;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.result_kind    = r_out.result_kind;
    assign o_out.integer_value  = r_out.integer_value;
    assign o_out.payload_byte   = r_out.payload_byte;
    assign o_out.last_of_string = r_out.last_of_string;
    assign o_out.error_code     = r_out.error_code;

    // payload mode always has at least one byte left to pass
    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.mode == MODE_PAYLOAD |-> r_state.remaining != '0)
        else $error("payload mode with zero bytes remaining");

    // byte count only lives in payload mode
    a_remaining_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.mode != MODE_PAYLOAD |-> r_state.remaining == '0)
        else $error("stale byte count outside payload mode");

    // sign and digit flags only belong to an integer token
    a_int_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.mode != MODE_INT |-> !r_state.negative && !r_state.digit_seen)
        else $error("integer flags set outside integer mode");

    // an item waiting in the output register is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !advance)
        else $error("input stage advanced over a stalled result");

    // error items carry a defined code and no payload
    a_error_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.result_kind == KIND_ERROR |->
            r_out.error_code <= ERR_LENGTH && r_out.payload_byte == '0
            && !r_out.last_of_string)
        else $error("malformed error item");

endmodule
